// ===== design/bine_pkg.sv =====
// Package for the B+ tree internal node engine.
// Holds the request and response structs, opcodes and status codes. No dependencies.
package bine_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_WIDTH_DEF = 32;

   localparam int OP_W     = 3;
   localparam int SKEY_W   = 32;
   localparam int CHILD_W  = 31;
   localparam int POS_W    = 6;
   localparam int NCOUNT_W = 7;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
   localparam logic [OP_W-1:0] OP_NEWROOT = 3'd1;
   localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd4;
   localparam logic [OP_W-1:0] OP_PREPEND = 3'd5;
   localparam logic [OP_W-1:0] OP_SPLIT   = 3'd6;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_ANCH = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [SKEY_W-1:0]  search_key;
      logic [CHILD_W-1:0] child_id;
      logic [CHILD_W-1:0] anchor_child;
      logic [POS_W-1:0]   position;
   } req_type;

   typedef struct packed {
      logic [CHILD_W-1:0]  child_out;
      logic                child_valid;
      logic [SKEY_W-1:0]   key_out;
      logic [NCOUNT_W-1:0] new_count;
      logic [STATUS_W-1:0] status;
      logic                last;
   } rsp_type;

endpackage

// ===== design/btree_internal_node_engine_top.sv =====
// Top level of the B+ tree internal node engine: sequencer around one storage RAM.
// Depends on bine_pkg and bine_ram.
//
//   channel | direction | payload  | handshake
//   req     | in        | req_type | req_valid / req_stall
//   rsp     | out       | rsp_type | rsp_valid / rsp_stall
//
// One request at a time; req_stall is high until its last response is registered.
// Lookup checks entries 0 and 1, then binary-searches the keys; insert, remove and
// prepend search or move one entry at a time through the single RAM port pair;
// split reads and emits one entry at a time. The others do not search or move entries.
// Reset empties the node at once. A stalled response holds the sequencer.
module btree_internal_node_engine_top
   import bine_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DISP, S_OUT,
      S_LK_C0, S_LK_C1, S_LK_LOOP, S_LK_CMP, S_LK_FIN,
      S_SRCH, S_SHUP, S_SHDN, S_INS_WR, S_PRE_WR, S_PRE_WR2,
      S_NR_WR, S_SP_RD, S_SP_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [CHILD_W-1:0]  child_ff, child_in;
   logic [CHILD_W-1:0]  anchor_ff, anchor_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]       idx_ff, idx_in, end_ff, end_in, gap_ff, gap_in;
   logic [AW-1:0]       pend_addr_ff, pend_addr_in, cmp_idx_ff, cmp_idx_in;
   logic                pend_ff, pend_in, issue_ff, issue_in, cmp_ff, cmp_in;
   logic [CHILD_W-1:0]  res_child_ff, res_child_in;
   logic                res_valid_ff, res_valid_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                 rd_en, we_key, we_child;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [KEY_WIDTH-1:0] rd_key, wr_key;
   logic [CHILD_W-1:0]   rd_child, wr_child;

   logic                 out_free;
   logic [CW:0]          mid_sum;
   logic [CW-1:0]        half, start;
   logic [LW:0]          pos_next;

   bine_ram #(.DEPTH(CAPACITY), .KW(KEY_WIDTH)) u_ram (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_child (rd_child),
      .wr_addr  (wr_addr),
      .we_key   (we_key),
      .we_child (we_child),
      .wr_key   (wr_key),
      .wr_child (wr_child)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign half     = count_ff >> 1;
   assign start    = count_ff - half;
   assign pos_next = {1'b0, LW'(pos_ff)} + (LW + 1)'(1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      child_in      = child_ff;
      anchor_in     = anchor_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      gap_in        = gap_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      issue_in      = issue_ff;
      cmp_in        = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      res_child_in  = res_child_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;
      we_key        = 1'b0;
      we_child      = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_key        = rd_key;
      wr_child      = rd_child;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.op;
               key_in    = KEY_WIDTH'(req_data.search_key);
               child_in  = req_data.child_id;
               anchor_in = req_data.anchor_child;
               pos_in    = req_data.position;
               state_in  = S_DISP;
            end
         end

         S_DISP: begin
            res_child_in  = '0;
            res_valid_in  = 1'b0;
            res_status_in = ST_OK;
            state_in      = S_OUT;
            unique case (op_ff)
               OP_LOOKUP: begin
                  if (count_ff != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = '0;
                     state_in = S_LK_C0;
                  end
               end
               OP_NEWROOT: begin
                  we_child = 1'b1;
                  wr_addr  = '0;
                  wr_child = anchor_ff;
                  state_in = S_NR_WR;
               end
               OP_INSERT: begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else if (count_ff == '0) begin
                     res_status_in = ST_NO_ANCH;
                  end else begin
                     idx_in   = '0;
                     state_in = S_SRCH;
                  end
               end
               OP_REMOVE: begin
                  if (LW'(pos_ff) >= LW'(count_ff)) begin
                     res_status_in = ST_BAD_POS;
                  end else if (pos_next < (LW + 1)'(count_ff)) begin
                     idx_in   = pos_next[AW-1:0];
                     issue_in = 1'b1;
                     state_in = S_SHDN;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               OP_APPEND: begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     we_key   = 1'b1;
                     we_child = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_key   = key_ff;
                     wr_child = child_ff;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_PREPEND: begin
                  if (count_ff >= CW'(CAPACITY)) begin
                     res_status_in = ST_FULL;
                  end else if (count_ff != '0) begin
                     gap_in   = '0;
                     idx_in   = AW'(count_ff - CW'(1));
                     issue_in = 1'b1;
                     state_in = S_SHUP;
                  end else begin
                     state_in = S_PRE_WR;
                  end
               end
               OP_SPLIT: begin
                  if (half != '0) begin
                     count_in = start;
                     idx_in   = start[AW-1:0];
                     end_in   = AW'(count_ff - CW'(1));
                     state_in = S_SP_RD;
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  count_in = '0;
               end
            endcase
         end

         S_LK_C0: begin
            res_child_in = rd_child;
            res_valid_in = 1'b1;
            if (count_ff == CW'(1)) begin
               state_in = S_OUT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(1);
               state_in = S_LK_C1;
            end
         end

         S_LK_C1: begin
            if (key_ff < rd_key) begin
               state_in = S_OUT;
            end else begin
               lo_in    = CW'(1);
               hi_in    = count_ff;
               state_in = S_LK_LOOP;
            end
         end

         S_LK_LOOP: begin
            rd_en = 1'b1;
            if ({1'b0, hi_ff} > ({1'b0, lo_ff} + (CW + 1)'(1))) begin
               rd_addr  = mid_sum[AW:1];
               idx_in   = mid_sum[AW:1];
               state_in = S_LK_CMP;
            end else begin
               rd_addr  = lo_ff[AW-1:0];
               state_in = S_LK_FIN;
            end
         end

         S_LK_CMP: begin
            state_in = S_LK_LOOP;
            if (key_ff > rd_key) begin
               lo_in = CW'(idx_ff);
            end else if (key_ff < rd_key) begin
               hi_in = CW'(idx_ff);
            end else begin
               res_child_in = rd_child;
               state_in     = S_OUT;
            end
         end

         S_LK_FIN: begin
            res_child_in = rd_child;
            state_in     = S_OUT;
         end

         S_SRCH: begin
            if (cmp_ff && rd_child == anchor_ff) begin
               // open a gap right after the anchor
               gap_in = cmp_idx_ff + AW'(1);
               if (CW'(cmp_idx_ff) + CW'(1) < count_ff) begin
                  idx_in   = AW'(count_ff - CW'(1));
                  issue_in = 1'b1;
                  state_in = S_SHUP;
               end else begin
                  state_in = S_INS_WR;
               end
            end else if (cmp_ff && CW'(cmp_idx_ff) + CW'(1) == count_ff) begin
               res_status_in = ST_NO_ANCH;
               state_in      = S_OUT;
            end else if (CW'(idx_ff) < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = idx_ff;
               cmp_in     = 1'b1;
               cmp_idx_in = idx_ff;
               idx_in     = idx_ff + AW'(1);
            end
         end

         S_SHUP: begin
            we_key   = pend_ff;
            we_child = pend_ff;
            if (issue_ff) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff;
               pend_in      = 1'b1;
               pend_addr_in = idx_ff + AW'(1);
               if (idx_ff == gap_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end else if (op_ff == OP_PREPEND) begin
               state_in = S_PRE_WR;
            end else begin
               state_in = S_INS_WR;
            end
         end

         S_SHDN: begin
            we_key   = pend_ff;
            we_child = pend_ff;
            if (issue_ff) begin
               rd_en        = 1'b1;
               rd_addr      = idx_ff;
               pend_in      = 1'b1;
               pend_addr_in = idx_ff - AW'(1);
               if (CW'(idx_ff) + CW'(1) == count_ff) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_OUT;
            end
         end

         S_INS_WR: begin
            we_key   = 1'b1;
            we_child = 1'b1;
            wr_addr  = gap_ff;
            wr_key   = key_ff;
            wr_child = child_ff;
            count_in = count_ff + CW'(1);
            state_in = S_OUT;
         end

         S_PRE_WR: begin
            we_child = 1'b1;
            wr_addr  = '0;
            wr_child = child_ff;
            state_in = S_PRE_WR2;
         end

         S_PRE_WR2: begin
            we_key   = 1'b1;
            wr_addr  = AW'(1);
            wr_key   = key_ff;
            count_in = count_ff + CW'(1);
            state_in = S_OUT;
         end

         S_NR_WR: begin
            we_key   = 1'b1;
            we_child = 1'b1;
            wr_addr  = AW'(1);
            wr_key   = key_ff;
            wr_child = child_ff;
            count_in = CW'(2);
            state_in = S_OUT;
         end

         S_SP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_SP_EMIT;
         end

         S_SP_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.child_out   = rd_child;
               rsp_data_in.child_valid = 1'b1;
               rsp_data_in.key_out     = SKEY_W'(rd_key);
               rsp_data_in.new_count   = NCOUNT_W'(count_ff);
               rsp_data_in.status      = ST_OK;
               rsp_data_in.last        = (idx_ff == end_ff);
               if (idx_ff == end_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = S_SP_RD;
               end
            end
         end

         S_OUT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.child_out   = res_child_ff;
               rsp_data_in.child_valid = res_valid_ff;
               rsp_data_in.key_out     = '0;
               rsp_data_in.new_count   = NCOUNT_W'(count_ff);
               rsp_data_in.status      = res_status_ff;
               rsp_data_in.last        = 1'b1;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         issue_ff     <= 1'b0;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         issue_ff     <= issue_in;
         cmp_ff       <= cmp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      child_ff      <= child_in;
      anchor_ff     <= anchor_in;
      pos_ff        <= pos_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      gap_ff        <= gap_in;
      pend_addr_ff  <= pend_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_child_ff  <= res_child_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// ===== design/bine_ram.sv =====
// Entry storage of the node: key and child arrays, one write and one read port.
// Separate write enables for key and child; read data registered. Uses bine_pkg.
module bine_ram
   import bine_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int KW    = KEY_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [KW-1:0]            rd_key,
   output logic [CHILD_W-1:0]       rd_child,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic                     we_key,
   input  logic                     we_child,
   input  logic [KW-1:0]            wr_key,
   input  logic [CHILD_W-1:0]       wr_child
);

   logic [KW-1:0]      key_mem [DEPTH];
   logic [CHILD_W-1:0] child_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we_key) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (we_child) begin
         child_mem[wr_addr] <= wr_child;
      end
      if (rd_en) begin
         rd_key   <= key_mem[rd_addr];
         rd_child <= child_mem[rd_addr];
      end
   end

endmodule

// ===== dv/btree_internal_node_engine_top_tb.sv =====
// Self-checking testbench for btree_internal_node_engine_top. Depends on bine_pkg.
// Drives directed and random node requests with random idling. Some directed rows
// carry their expected response; the rest are predicted from a node copy. All are compared.
module btree_internal_node_engine_top_tb;
   import bine_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_CAP   = CAPACITY_DEF;
   localparam int N_RANDOM   = 345;
   localparam int HOLD_CYCLE = 400;

   typedef struct {
      req_type rq;
      bit      typed;
      rsp_type rsp;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   btree_internal_node_engine_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // predicted node contents
   logic [SKEY_W-1:0]  node_keys [NODE_CAP];
   logic [CHILD_W-1:0] node_childs [NODE_CAP];
   int                 node_count;

   rsp_type     pending_rsp[$];
   dir_row_type dir_rows[$];
   bit          cur_typed;
   rsp_type     cur_rsp;
   int          mismatch_cnt;
   int          rsp_cnt;
   int          req_cnt;
   int          full_cnt;
   int          max_split;
   int          idle_pct;
   int          stall_pct;
   bit          hold_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("btree_internal_node_engine_top verification failed");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      mismatch_cnt++;
      $display("MISMATCH rsp %0d %s: got %0h want %0h", rsp_cnt, what, got, want);
   endtask

   function automatic logic [CHILD_W-1:0] find_child(logic [SKEY_W-1:0] k);
      int lo;
      int hi;
      int mid;
      lo = 1;
      hi = node_count;
      if (node_count == 1 || k < node_keys[1]) return node_childs[0];
      while (hi > lo + 1) begin
         mid = (lo + hi) / 2;
         if (k > node_keys[mid]) lo = mid;
         else if (k < node_keys[mid]) hi = mid;
         else return node_childs[mid];
      end
      return node_childs[lo];
   endfunction

   function automatic rsp_type mk_rsp(logic [CHILD_W-1:0] c, logic v, logic [SKEY_W-1:0] k,
                                      logic [STATUS_W-1:0] st, logic l);
      rsp_type r;
      r.child_out   = c;
      r.child_valid = v;
      r.key_out     = k;
      r.new_count   = NCOUNT_W'(node_count);
      r.status      = st;
      r.last        = l;
      return r;
   endfunction

   // shift slots at..count-1 up by one
   function automatic void open_gap(int at);
      for (int i = node_count; i > at; i--) begin
         node_keys[i]   = node_keys[i-1];
         node_childs[i] = node_childs[i-1];
      end
   endfunction

   // update the node for one request and queue the responses it causes
   function automatic void node_apply(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type outq[$];
      int      at;
      int      n;
      int      start;
      case (r.op)
         OP_LOOKUP: begin
            if (node_count == 0) outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
            else outq.push_back(mk_rsp(find_child(r.search_key), 1'b1, '0, ST_OK, 1'b1));
         end
         OP_NEWROOT: begin
            node_childs[0] = r.anchor_child;
            node_keys[1]   = r.search_key;
            node_childs[1] = r.child_id;
            node_count     = 2;
            outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
         end
         OP_INSERT: begin
            at = node_count;
            if (node_count >= NODE_CAP) begin
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_FULL, 1'b1));
            end else begin
               for (int i = 0; i < node_count; i++) begin
                  if (node_childs[i] == r.anchor_child) begin
                     at = i;
                     break;
                  end
               end
               if (at == node_count) begin
                  outq.push_back(mk_rsp('0, 1'b0, '0, ST_NO_ANCH, 1'b1));
               end else begin
                  open_gap(at + 1);
                  node_keys[at+1]   = r.search_key;
                  node_childs[at+1] = r.child_id;
                  node_count++;
                  outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
               end
            end
         end
         OP_REMOVE: begin
            if (r.position >= node_count) begin
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_BAD_POS, 1'b1));
            end else begin
               for (int i = r.position + 1; i < node_count; i++) begin
                  node_keys[i-1]   = node_keys[i];
                  node_childs[i-1] = node_childs[i];
               end
               node_count--;
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
            end
         end
         OP_APPEND: begin
            if (node_count >= NODE_CAP) begin
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_FULL, 1'b1));
            end else begin
               node_keys[node_count]   = r.search_key;
               node_childs[node_count] = r.child_id;
               node_count++;
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
            end
         end
         OP_PREPEND: begin
            if (node_count >= NODE_CAP) begin
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_FULL, 1'b1));
            end else begin
               open_gap(0);
               node_childs[0] = r.child_id;
               node_count++;
               node_keys[1] = r.search_key;
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
            end
         end
         OP_SPLIT: begin
            n     = node_count / 2;
            start = node_count - n;
            if (n == 0) begin
               outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
            end else begin
               node_count = start;
               if (n > max_split) max_split = n;
               for (int i = 0; i < n; i++)
                  outq.push_back(mk_rsp(node_childs[start+i], 1'b1, node_keys[start+i],
                                        ST_OK, i + 1 == n));
            end
         end
         default: begin
            node_count = 0;
            outq.push_back(mk_rsp('0, 1'b0, '0, ST_OK, 1'b1));
         end
      endcase
      if (outq.size() == 1 && outq[0].status == ST_FULL) full_cnt++;
      if (typed) pending_rsp.push_back(typed_rsp);
      else foreach (outq[i]) pending_rsp.push_back(outq[i]);
   endfunction

   task automatic cur_exp_check(input rsp_type want);
      if (rsp_data.child_out !== want.child_out)
         flag_mismatch("child_out", 64'(rsp_data.child_out), 64'(want.child_out));
      if (rsp_data.child_valid !== want.child_valid)
         flag_mismatch("child_valid", 64'(rsp_data.child_valid), 64'(want.child_valid));
      if (rsp_data.key_out !== want.key_out)
         flag_mismatch("key_out", 64'(rsp_data.key_out), 64'(want.key_out));
      if (rsp_data.new_count !== want.new_count)
         flag_mismatch("new_count", 64'(rsp_data.new_count), 64'(want.new_count));
      if (rsp_data.status !== want.status)
         flag_mismatch("status", 64'(rsp_data.status), 64'(want.status));
      if (rsp_data.last !== want.last)
         flag_mismatch("last", 64'(rsp_data.last), 64'(want.last));
   endtask

   // accept requests and check responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            node_apply(req_data, cur_typed, cur_rsp);
            req_cnt++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               flag_mismatch("unexpected response", 64'(rsp_data), '0);
            end else begin
               cur_exp_check(pending_rsp.pop_front());
            end
            rsp_cnt++;
         end
      end
   end

   // response side: random stall, or a long hold when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLE) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   function automatic req_type mk_req(logic [OP_W-1:0] op, logic [SKEY_W-1:0] k,
                                      logic [CHILD_W-1:0] c, logic [CHILD_W-1:0] a,
                                      logic [POS_W-1:0] p);
      req_type r;
      r.op           = op;
      r.search_key   = k;
      r.child_id     = c;
      r.anchor_child = a;
      r.position     = p;
      return r;
   endfunction

   function automatic void add_row(req_type rq, bit typed, rsp_type rsp);
      dir_row_type d;
      d.rq    = rq;
      d.typed = typed;
      d.rsp   = rsp;
      dir_rows.push_back(d);
   endfunction

   function automatic rsp_type tr(logic [CHILD_W-1:0] c, logic v, logic [SKEY_W-1:0] k,
                                  int cnt, logic [STATUS_W-1:0] st);
      rsp_type r;
      r.child_out   = c;
      r.child_valid = v;
      r.key_out     = k;
      r.new_count   = NCOUNT_W'(cnt);
      r.status      = st;
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic void build_rows();
      rsp_type none;
      none = '0;
      add_row(mk_req(OP_LOOKUP, 32'h1234, 0, 0, 0), 1, tr(0, 0, 0, 0, ST_OK));
      add_row(mk_req(OP_SPLIT, 0, 0, 0, 0), 1, tr(0, 0, 0, 0, ST_OK));
      add_row(mk_req(OP_REMOVE, 0, 0, 0, 0), 1, tr(0, 0, 0, 0, ST_BAD_POS));
      add_row(mk_req(OP_INSERT, 7, 9, 5, 0), 1, tr(0, 0, 0, 0, ST_NO_ANCH));
      add_row(mk_req(OP_APPEND, 0, 0, 0, 0), 1, tr(0, 0, 0, 1, ST_OK));
      add_row(mk_req(OP_LOOKUP, '1, 0, 0, 0), 1, tr(0, 1, 0, 1, ST_OK));
      add_row(mk_req(OP_PREPEND, '1, '1, 0, 0), 1, tr(0, 0, 0, 2, ST_OK));
      add_row(mk_req(OP_SPLIT, 0, 0, 0, 0), 1, tr(0, 1, '1, 1, ST_OK));
      add_row(mk_req(OP_NEWROOT, 1000, 1, '1, 0), 1, tr(0, 0, 0, 2, ST_OK));
      add_row(mk_req(OP_APPEND, 2000, 2, 0, '1), 0, none);
      add_row(mk_req(OP_INSERT, 1500, 3, 1, 0), 0, none);
      add_row(mk_req(OP_INSERT, 500, 4, '1, 0), 0, none);
      add_row(mk_req(OP_LOOKUP, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_LOOKUP, 1500, 0, 0, 0), 0, none);
      add_row(mk_req(OP_LOOKUP, '1, 0, 0, 0), 0, none);
      add_row(mk_req(OP_LOOKUP, 1200, 0, 0, 0), 0, none);
      add_row(mk_req(OP_REMOVE, 0, 0, 0, '1), 1, tr(0, 0, 0, 5, ST_BAD_POS));
      add_row(mk_req(OP_REMOVE, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_REMOVE, 0, 0, 0, 3), 0, none);
      add_row(mk_req(OP_INSERT, 1, 1, 12345, 0), 1, tr(0, 0, 0, 3, ST_NO_ANCH));
      add_row(mk_req(OP_APPEND, 0, '1, 0, 0), 0, none);
      add_row(mk_req(OP_SPLIT, 0, 0, 0, 0), 0, none);
      add_row(mk_req(OP_CLEAR, '1, '1, '1, '1), 1, tr(0, 0, 0, 0, ST_OK));
      add_row(mk_req(OP_PREPEND, 32'hABCD, 9, 0, 0), 1, tr(0, 0, 0, 1, ST_OK));
      add_row(mk_req(OP_LOOKUP, 77, 0, 0, 0), 0, none);
   endfunction

   // random request, biased toward growing the node when grow is set
   function automatic req_type gen_req(bit grow);
      req_type r;
      int      w;
      r = mk_req(OP_LOOKUP, $urandom, CHILD_W'($urandom), CHILD_W'($urandom),
                 POS_W'($urandom));
      case ($urandom_range(7))
         0: r.search_key = '0;
         1: r.search_key = '1;
         2: r.child_id   = '1;
         3: r.child_id   = '0;
         default: ;
      endcase
      w = $urandom_range(99);
      if (grow) begin
         if (w < 40) r.op = OP_APPEND;
         else if (w < 65) r.op = OP_INSERT;
         else if (w < 85) r.op = OP_PREPEND;
         else if (w < 95) r.op = OP_LOOKUP;
         else r.op = OP_REMOVE;
      end else begin
         if (w < 30) r.op = OP_LOOKUP;
         else if (w < 42) r.op = OP_APPEND;
         else if (w < 54) r.op = OP_INSERT;
         else if (w < 68) r.op = OP_REMOVE;
         else if (w < 76) r.op = OP_PREPEND;
         else if (w < 90) r.op = OP_SPLIT;
         else if (w < 95) r.op = OP_NEWROOT;
         else r.op = OP_CLEAR;
      end
      if (node_count > 0 && $urandom_range(99) < 85) begin
         r.anchor_child = node_childs[$urandom_range(node_count - 1)];
         r.position     = POS_W'($urandom_range(node_count - 1));
      end
      if (r.op == OP_LOOKUP && node_count > 1 && $urandom_range(99) < 40)
         r.search_key = node_keys[$urandom_range(node_count - 1, 1)] +
                        SKEY_W'($urandom_range(2)) - 1;
      return r;
   endfunction

   // offer one request and hold it until accepted
   task automatic send_req(input req_type r, input bit typed, input rsp_type rsp);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      cur_typed = typed;
      cur_rsp   = rsp;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
   endtask

   initial begin
      int phase;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      cur_typed    = 1'b0;
      cur_rsp      = '0;
      hold_req     = 1'b0;
      idle_pct     = 0;
      stall_pct    = 0;
      mismatch_cnt = 0;
      rsp_cnt      = 0;
      req_cnt      = 0;
      full_cnt     = 0;
      max_split    = 0;
      node_count   = 0;
      build_rows();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rsp);

      for (int i = 0; i < N_RANDOM; i++) begin
         phase = i * 4 / N_RANDOM;
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 55; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         // hold off responses for a while so the engine backs up
         if (i == N_RANDOM / 2 + 10) hold_req = 1'b1;
         send_req(gen_req((i % (N_RANDOM / 4)) < 55), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (pending_rsp.size() != 0)
         flag_mismatch("responses missing", 64'(pending_rsp.size()), '0);

      $display("Sent %0d requests of all eight operations, checked %0d responses.",
               req_cnt, rsp_cnt);
      $display("Node-full rejects: %0d, largest split: %0d entries.", full_cnt, max_split);
      if (mismatch_cnt == 0) begin
         $display("btree_internal_node_engine_top verification clean");
      end else begin
         $display("btree_internal_node_engine_top verification failed");
      end
      $finish;
   end

endmodule

// ===== btree_internal_node_engine_top.f =====
design/bine_pkg.sv
design/bine_ram.sv
design/btree_internal_node_engine_top.sv
dv/btree_internal_node_engine_top_tb.sv
